// ===== rtl/gelu_tanh_rational_approx_top_assert.svh =====
// Assertion macros shared by the GELU block's checker.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef GELU_TANH_RATIONAL_APPROX_TOP_ASSERT_SVH
`define GELU_TANH_RATIONAL_APPROX_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GTRA_ASSERT_IMP(lbl, clk, rstn, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GTRA_ASSERT_NXT(lbl, clk, rstn, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (con)) \
        else $error(msg);

`endif

// ===== rtl/gtra_pkg.sv =====
// Shared constants and types for the GELU (tanh form) pipeline.
// Depends on nothing; every module file imports it.
package gtra_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QB        = 24;
    localparam int QSH       = QB - FRAC_BITS;

    localparam logic [63:0] QONE    = 64'd1 << QB;
    localparam logic [63:0] K_CUBIC = 64'd750193;
    localparam logic [63:0] K_SCALE = 64'd13386282;
    localparam logic [63:0] U_MAX   = 64'd5 * QONE;
    localparam logic [31:0] BIG_MAG = 32'd8 << FRAC_BITS;

    localparam int DIV_STAGES = 13;
    localparam int Q_BITS     = 2 * DIV_STAGES;

    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
        logic        last;
    } t_side;

    typedef struct packed {
        logic  valid;
        t_side side;
    } t_ctl;

endpackage

// ===== rtl/gtra_uarg.sv =====
// Six-stage front end: |x|, then u = 0.79788458*x*(1+0.044715*x^2) clamped, then u^2.
// Depends on gtra_pkg.
module gtra_uarg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [31:0]        i_x,
    input  logic               i_last,
    output gtra_pkg::t_ctl     o_ctl,
    output logic [26:0]        o_um,
    output logic [28:0]        o_v2
);
    import gtra_pkg::*;

    t_ctl        r_ctl1, r_ctl2, r_ctl3, r_ctl4, r_ctl5, r_ctl6;
    logic [26:0] r_m1, r_m2, r_m3;
    logic        r_big1, r_big2, r_big3, r_big4;
    logic [29:0] r_x2;
    logic [25:0] r_t;
    logic [28:0] r_t2;
    logic [26:0] r_um5, r_um6;
    logic [28:0] r_v2;

    logic [31:0] n_mag;
    logic [53:0] n_sq;
    logic [49:0] n_cub;
    logic [52:0] n_tm;
    logic [52:0] n_sc;
    logic [28:0] n_u;
    logic [53:0] n_usq;

    always_comb begin
        n_mag = i_x[31] ? (~i_x + 32'd1) : i_x;
        n_sq  = 54'(r_m1) * 54'(r_m1);
        n_cub = 50'(r_x2) * 50'(K_CUBIC);
        n_tm  = 53'(r_t) * 53'(r_m3);
        n_sc  = 53'(r_t2) * 53'(K_SCALE);
        n_u   = 29'(n_sc >> QB);
        n_usq = 54'(r_um5) * 54'(r_um5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
            r_ctl2.valid <= 1'b0;
            r_ctl3.valid <= 1'b0;
            r_ctl4.valid <= 1'b0;
            r_ctl5.valid <= 1'b0;
            r_ctl6.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl1.valid <= i_valid;
            r_ctl2.valid <= r_ctl1.valid;
            r_ctl3.valid <= r_ctl2.valid;
            r_ctl4.valid <= r_ctl3.valid;
            r_ctl5.valid <= r_ctl4.valid;
            r_ctl6.valid <= r_ctl5.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl1.side <= '{neg: i_x[31], mag: n_mag, last: i_last};
            // Only the low bits matter when the magnitude is below eight.
            r_m1   <= 27'(n_mag) << QSH;
            r_big1 <= (n_mag >= BIG_MAG);

            r_ctl2.side <= r_ctl1.side;
            r_m2   <= r_m1;
            r_big2 <= r_big1;
            r_x2   <= 30'(n_sq >> QB);

            r_ctl3.side <= r_ctl2.side;
            r_m3   <= r_m2;
            r_big3 <= r_big2;
            r_t    <= 26'(n_cub >> QB) + 26'(QONE);

            r_ctl4.side <= r_ctl3.side;
            r_big4 <= r_big3;
            r_t2   <= 29'(n_tm >> QB);

            r_ctl5.side <= r_ctl4.side;
            if (r_big4 || (n_u > 29'(U_MAX))) begin
                r_um5 <= 27'(U_MAX);
            end else begin
                r_um5 <= 27'(n_u);
            end

            r_ctl6.side <= r_ctl5.side;
            r_um6 <= r_um5;
            r_v2  <= 29'(n_usq >> QB);
        end
    end

    assign o_ctl = r_ctl6;
    assign o_um  = r_um6;
    assign o_v2  = r_v2;
endmodule

// ===== rtl/gtra_ratpoly.sv =====
// Six-stage numerator and denominator of the rational tanh form.
// Wide products are split into two partial products and summed a stage later.
// Depends on gtra_pkg.
module gtra_ratpoly (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  gtra_pkg::t_ctl     i_ctl,
    input  logic [26:0]        i_um,
    input  logic [28:0]        i_v2,
    output gtra_pkg::t_ctl     o_ctl,
    output logic [46:0]        o_num,
    output logic [46:0]        o_den
);
    import gtra_pkg::*;

    t_ctl        r_ctl7, r_ctl8, r_ctl9, r_ctl10, r_ctl11, r_ctl12;
    logic [26:0] r_um7, r_um8, r_um9, r_um10;
    logic [28:0] r_v7, r_v8;
    logic [48:0] r_nl7, r_dl7;
    logic [41:0] r_nh7;
    logic [44:0] r_dh7;
    logic [37:0] r_n1;
    logic [41:0] r_d1;
    logic [48:0] r_nl9, r_dl9;
    logic [47:0] r_nh9;
    logic [50:0] r_dh9;
    logic [43:0] r_n2;
    logic [46:0] r_den10, r_den11, r_den12;
    logic [46:0] r_nl11;
    logic [50:0] r_nh11;
    logic [46:0] r_num;

    logic [32:0] n_a;
    logic [35:0] n_dn;
    logic [38:0] n_b;
    logic [43:0] n_c;
    logic [61:0] n_s8n;
    logic [64:0] n_s8d;
    logic [67:0] n_s10n;
    logic [70:0] n_s10d;
    logic [70:0] n_s12;

    always_comb begin
        n_a    = 33'(i_v2) + 33'(64'd378 * QONE);
        n_dn   = 36'(i_v2) * 36'd28 + 36'(64'd3150 * QONE);
        n_s8n  = (62'(r_nh7) << 20) + 62'(r_nl7);
        n_s8d  = (65'(r_dh7) << 20) + 65'(r_dl7);
        n_b    = 39'(r_n1) + 39'(64'd17325 * QONE);
        n_s10n = (68'(r_nh9) << 20) + 68'(r_nl9);
        n_s10d = (71'(r_dh9) << 20) + 71'(r_dl9);
        n_c    = 44'(r_n2) + 44'(64'd135135 * QONE);
        n_s12  = (71'(r_nh11) << 20) + 71'(r_nl11);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl7.valid  <= 1'b0;
            r_ctl8.valid  <= 1'b0;
            r_ctl9.valid  <= 1'b0;
            r_ctl10.valid <= 1'b0;
            r_ctl11.valid <= 1'b0;
            r_ctl12.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl7.valid  <= i_ctl.valid;
            r_ctl8.valid  <= r_ctl7.valid;
            r_ctl9.valid  <= r_ctl8.valid;
            r_ctl10.valid <= r_ctl9.valid;
            r_ctl11.valid <= r_ctl10.valid;
            r_ctl12.valid <= r_ctl11.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl7.side <= i_ctl.side;
            r_um7 <= i_um;
            r_v7  <= i_v2;
            r_nl7 <= 49'(n_a[19:0]) * 49'(i_v2);
            r_nh7 <= 42'(n_a[32:20]) * 42'(i_v2);
            r_dl7 <= 49'(n_dn[19:0]) * 49'(i_v2);
            r_dh7 <= 45'(n_dn[35:20]) * 45'(i_v2);

            r_ctl8.side <= r_ctl7.side;
            r_um8 <= r_um7;
            r_v8  <= r_v7;
            r_n1  <= 38'(n_s8n >> QB);
            r_d1  <= 42'(n_s8d >> QB) + 42'(64'd62370 * QONE);

            r_ctl9.side <= r_ctl8.side;
            r_um9 <= r_um8;
            r_nl9 <= 49'(n_b[19:0]) * 49'(r_v8);
            r_nh9 <= 48'(n_b[38:20]) * 48'(r_v8);
            r_dl9 <= 49'(r_d1[19:0]) * 49'(r_v8);
            r_dh9 <= 51'(r_d1[41:20]) * 51'(r_v8);

            r_ctl10.side <= r_ctl9.side;
            r_um10  <= r_um9;
            r_n2    <= 44'(n_s10n >> QB);
            r_den10 <= 47'(n_s10d >> QB) + 47'(64'd135135 * QONE);

            r_ctl11.side <= r_ctl10.side;
            r_den11 <= r_den10;
            r_nl11  <= 47'(n_c[19:0]) * 47'(r_um10);
            r_nh11  <= 51'(n_c[43:20]) * 51'(r_um10);

            r_ctl12.side <= r_ctl11.side;
            r_den12 <= r_den11;
            r_num   <= 47'(n_s12 >> QB);
        end
    end

    assign o_ctl = r_ctl12;
    assign o_num = r_num;
    assign o_den = r_den12;
endmodule

// ===== rtl/gtra_div.sv =====
// Pipelined restoring divider: two quotient bits per stage, floor(num * 2^24 / den).
// Depends on gtra_pkg.
module gtra_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  gtra_pkg::t_ctl                i_ctl,
    input  logic [46:0]                   i_num,
    input  logic [46:0]                   i_den,
    output gtra_pkg::t_ctl                o_ctl,
    output logic [gtra_pkg::Q_BITS-1:0]   o_q
);
    import gtra_pkg::*;

    // The divisor is scaled by four so that the remainder starts below it
    // and all quotient bits, two integer ones included, come out uniformly.
    t_ctl              r_ctl [DIV_STAGES];
    logic [48:0]       r_rem [DIV_STAGES];
    logic [48:0]       r_dv  [DIV_STAGES];
    logic [Q_BITS-1:0] r_q   [DIV_STAGES];

    function automatic logic [49:0] div_step(input logic [48:0] rem, input logic [48:0] dv);
        logic [49:0] sh;
        logic        ge;
        sh = {rem, 1'b0};
        ge = (sh >= {1'b0, dv});
        // Bit 49 carries the quotient bit, the low bits the new remainder.
        return {ge, ge ? 49'(sh - {1'b0, dv}) : 49'(sh)};
    endfunction

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [48:0]       n_rem_in, n_dv_in;
        logic [Q_BITS-1:0] n_q_in;
        t_ctl              n_ctl_in;
        logic [49:0]       n_s0, n_s1;

        if (g == 0) begin : g_first
            assign n_rem_in = 49'(i_num);
            assign n_dv_in  = {i_den, 2'b00};
            assign n_q_in   = '0;
            assign n_ctl_in = i_ctl;
        end else begin : g_next
            assign n_rem_in = r_rem[g-1];
            assign n_dv_in  = r_dv[g-1];
            assign n_q_in   = r_q[g-1];
            assign n_ctl_in = r_ctl[g-1];
        end

        assign n_s0 = div_step(n_rem_in, n_dv_in);
        assign n_s1 = div_step(n_s0[48:0], n_dv_in);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g].valid <= 1'b0;
            end else if (i_en) begin
                r_ctl[g].valid <= n_ctl_in.valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[g].side <= n_ctl_in.side;
                r_rem[g] <= n_s1[48:0];
                r_dv[g]  <= n_dv_in;
                r_q[g]   <= {n_q_in[Q_BITS-3:0], n_s0[49], n_s1[49]};
            end
        end
    end

    assign o_ctl = r_ctl[DIV_STAGES-1];
    assign o_q   = r_q[DIV_STAGES-1];
endmodule

// ===== rtl/gelu_tanh_rational_approx_top.sv =====
// Top level of the fixed-point GELU (tanh form): front end, rational polynomial,
// divider, then scaling, rounding and saturation. Depends on gtra_pkg and the
// modules gtra_uarg, gtra_ratpoly and gtra_div.
//
//  channel   direction  payload                        handshake
//  s_axis    in         tdata = x_sample, tlast = last_in    tvalid/tready
//  m_axis    out        tdata = y_result, tlast = last_out   tvalid/tready
//
// One request enters per cycle while m_axis is not stalled; there are 27 register
// stages between the s_axis input and the registered m_axis output.
// Most of them lie in the 13-stage divider and the split multiplies ahead of it.
// Reset clears every valid bit in the pipeline; data registers are not reset.
// While a result waits on a low m_axis_tready the whole pipeline holds and
// s_axis_tready is low; nothing is dropped or repeated.
module gelu_tanh_rational_approx_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] x_sample
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] y_result
    output logic        o_m_axis_tlast
);
    import gtra_pkg::*;

    logic              n_en;
    t_ctl              n_ctl_u, n_ctl_p, n_ctl_d;
    logic [26:0]       n_um;
    logic [28:0]       n_v2;
    logic [46:0]       n_num, n_den;
    logic [Q_BITS-1:0] n_q, n_qc;
    logic [25:0]       n_s;
    logic [57:0]       n_r58;
    logic [32:0]       n_r;
    logic [31:0]       n_y;

    t_ctl              r_ctl_p;
    logic [57:0]       r_prod;
    logic              r_out_valid;
    logic [31:0]       r_out_data;
    logic              r_out_last;

    assign n_en = !r_out_valid || i_m_axis_tready;

    gtra_uarg u_uarg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (i_s_axis_tvalid),
        .i_x     (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_ctl   (n_ctl_u),
        .o_um    (n_um),
        .o_v2    (n_v2)
    );

    gtra_ratpoly u_ratpoly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (n_ctl_u),
        .i_um    (n_um),
        .i_v2    (n_v2),
        .o_ctl   (n_ctl_p),
        .o_num   (n_num),
        .o_den   (n_den)
    );

    gtra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (n_ctl_p),
        .i_num   (n_num),
        .i_den   (n_den),
        .o_ctl   (n_ctl_d),
        .o_q     (n_q)
    );

    always_comb begin
        n_qc = (n_q > Q_BITS'(QONE)) ? Q_BITS'(QONE) : n_q;
        n_s  = n_ctl_d.side.neg ? (26'(QONE) - 26'(n_qc)) : (26'(QONE) + 26'(n_qc));
        // The shift by 25 takes the factor one half and the tanh fraction together.
        n_r58 = (r_prod + 58'(QONE)) >> (QB + 1);
        n_r   = 33'(n_r58);
        if (r_ctl_p.side.neg) begin
            n_y = (n_r > 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - 32'(n_r));
        end else begin
            n_y = (n_r > 33'h0_7fff_ffff) ? 32'h7fff_ffff : 32'(n_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_p.valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (n_en) begin
            r_ctl_p.valid <= n_ctl_d.valid;
            r_out_valid   <= r_ctl_p.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_ctl_p.side <= n_ctl_d.side;
            r_prod       <= 58'(n_ctl_d.side.mag) * 58'(n_s);
            r_out_data   <= n_y;
            r_out_last   <= r_ctl_p.side.last;
        end
    end

    assign o_s_axis_tready = n_en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
endmodule

// ===== rtl/gtra_checker.sv =====
// Port-level checks for the GELU block, attached to the top level by bind.
// Depends on gtra_pkg and the assertion macro header.
`include "gelu_tanh_rational_approx_top_assert.svh"

module gtra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    import gtra_pkg::*;

    logic n_in_seen;
    assign n_in_seen = i_s_axis_tvalid || i_s_axis_tlast || (|i_s_axis_tdata) || o_m_axis_tlast;

    // The input side only waits when a result is stuck at the output.
    `GTRA_ASSERT_IMP(a_ready_follows_out, i_clk, i_rst_n, 1'b1, o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready) || !n_in_seen && o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready), "input ready does not follow output state")

    // GELU never falls below minus one, so a negative result has all integer bits set.
    `GTRA_ASSERT_IMP(a_neg_bound, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[31], &o_m_axis_tdata[31:FRAC_BITS], "negative result below minus one")

    // A result that is not taken stays offered.
    `GTRA_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")
endmodule

bind gelu_tanh_rational_approx_top gtra_checker u_gtra_checker (.*);
